// ===== hdl/bml_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_pkg: shared types and constants of the byte memory load/store block
// Memory geometry, access codes and the payload structs of both ports.
// ----------------------------------------------------------------------------
package bml_pkg;

  // geometry: four byte lanes, one bank per lane
  localparam int unsigned MemBytes = 4096;
  localparam int unsigned AddrW    = $clog2(MemBytes);
  localparam int unsigned NumLanes = 4;
  localparam int unsigned LaneW    = 2;
  localparam int unsigned RowW     = AddrW - LaneW;
  localparam int unsigned RowCnt   = MemBytes / NumLanes;
  localparam int unsigned LimW     = AddrW + 1;
  localparam int unsigned CfgW     = 13;

  localparam logic [7:0] FillByte = 8'hA5;

  // operation codes
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // access size codes; the fourth code acts as a word
  localparam logic [1:0] SzByte = 2'd0;
  localparam logic [1:0] SzHalf = 2'd1;
  localparam logic [1:0] SzWord = 2'd2;

  typedef struct packed {
    logic        op;
    logic [1:0]  access_size;
    logic        sign_extend;
    logic [31:0] addr;
    logic [31:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        out_of_range;
  } out_item_t;

  // one bank access
  typedef struct packed {
    logic            we;
    logic [RowW-1:0] row;
    logic [7:0]      wbyte;
  } lane_req_t;

  // what the read assembly needs to know about an access
  typedef struct packed {
    logic                op;
    logic [1:0]          access_size;
    logic                sign_extend;
    logic [LaneW-1:0]    offset;
    logic [NumLanes-1:0] byte_ok;
    logic                oor;
  } acc_info_t;

endpackage

// ===== hdl/bml_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_bank: one byte-lane bank
// Single-port byte RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module bml_bank
  import bml_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [RowW-1:0] row_i,
  input  logic [7:0]      wbyte_i,
  output logic [7:0]      rbyte_o
);

  logic [7:0] mem [RowCnt];
  logic [7:0] rbyte_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[row_i] <= wbyte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rbyte_q <= mem[row_i];
  end

  assign rbyte_o = rbyte_q;

endmodule

// ===== hdl/bml_addr_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_addr_gen: lane steering and range check
// Maps the up to four touched bytes onto the four banks and checks each
// byte address against the limit.
// ----------------------------------------------------------------------------
module bml_addr_gen
  import bml_pkg::*;
(
  input  in_item_t                 item_i,
  input  logic [LimW-1:0]          lim_i,
  output lane_req_t [NumLanes-1:0] req_o,
  output acc_info_t                info_o
);

  logic [NumLanes-1:0][31:0] byte_addr;
  logic [NumLanes-1:0]       touched;
  logic [NumLanes-1:0]       in_rng;
  logic [NumLanes-1:0]       ok;
  logic [LaneW-1:0]          k_sel [NumLanes];

  always_comb begin
    unique case (item_i.access_size)
      SzByte:  touched = 4'b0001;
      SzHalf:  touched = 4'b0011;
      default: touched = 4'b1111;
    endcase
  end

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      byte_addr[k] = item_i.addr + 32'(k);
      in_rng[k]    = byte_addr[k] < 32'(lim_i);
      ok[k]        = touched[k] & in_rng[k];
    end
  end

  // bank b holds byte k where (addr + k) mod 4 == b
  always_comb begin
    for (int b = 0; b < NumLanes; b++) begin
      k_sel[b]       = LaneW'(b) - item_i.addr[LaneW-1:0];
      req_o[b].row   = byte_addr[k_sel[b]][AddrW-1:LaneW];
      req_o[b].we    = (item_i.op == OpWrite) & ok[k_sel[b]];
      req_o[b].wbyte = item_i.wdata[{k_sel[b], 3'b000} +: 8];
    end
  end

  assign info_o.op          = item_i.op;
  assign info_o.access_size = item_i.access_size;
  assign info_o.sign_extend = item_i.sign_extend;
  assign info_o.offset      = item_i.addr[LaneW-1:0];
  assign info_o.byte_ok     = ok;
  assign info_o.oor         = |(touched & ~in_rng);

endmodule

// ===== hdl/byte_memory_load_store.sv =====
`timescale 1ns / 1ps
// Start transfers pass the input, bank and result registers to done_o.
// Throughput: one access per cycle while busy is low, set by the single
// bank port per lane. Reset: the fill pass writes 0xA5 to every byte, one
// row of all four banks per cycle, over all RowCnt rows (1024 for 4096
// bytes); busy stays high meanwhile. Config writes are taken at all times.
// Results cannot be stalled: done_o marks each one for a single cycle.
// ----------------------------------------------------------------------------
// byte_memory_load_store: little-endian byte-addressed data memory
// Byte, halfword or word loads and stores at any byte address, with
// per-byte range check against a configurable size in use.
// ----------------------------------------------------------------------------
module byte_memory_load_store
  import bml_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // command channel
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_i,
  // result channel
  output logic            done_o,
  output out_item_t       result_o,
  // size-in-use register
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // fill pass after reset
  // --------------------------------------------------------------------------
  logic            clr_busy_q;
  logic [RowW-1:0] clr_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + RowW'(1);
      if (clr_row_q == RowW'(RowCnt - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign busy = clr_busy_q;

  // --------------------------------------------------------------------------
  // limit register: size rounded up to 16 bytes, saturated at the memory size
  // --------------------------------------------------------------------------
  logic [LimW-1:0] lim_q;
  logic [LimW-1:0] lim_d;
  logic [CfgW:0]   cfg_round;

  assign cfg_ready_o = 1'b1;
  assign cfg_round   = ({1'b0, cfg_data_i} + (CfgW+1)'(15)) & ~(CfgW+1)'(15);

  always_comb begin
    if (32'(cfg_round) > MemBytes) begin
      lim_d = LimW'(MemBytes);
    end else begin
      lim_d = LimW'(cfg_round);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimW'(MemBytes);
    end else if (cfg_valid_i && cfg_ready_o) begin
      lim_q <= lim_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register
  // --------------------------------------------------------------------------
  logic     accept;
  logic     s1_vld_q;
  in_item_t s1_item_q;

  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: lane steering and bank access (write commits here)
  // --------------------------------------------------------------------------
  lane_req_t [NumLanes-1:0] req;
  acc_info_t                info;
  logic      [NumLanes-1:0][7:0] rbyte;

  bml_addr_gen u_addr_gen (
    .item_i (s1_item_q),
    .lim_i  (lim_q),
    .req_o  (req),
    .info_o (info)
  );

  for (genvar b = 0; b < NumLanes; b++) begin : g_bank
    logic            bank_we;
    logic [RowW-1:0] bank_row;
    logic [7:0]      bank_wbyte;

    // fill pass owns the banks until it is done
    assign bank_we    = clr_busy_q | (s1_vld_q & req[b].we);
    assign bank_row   = clr_busy_q ? clr_row_q : req[b].row;
    assign bank_wbyte = clr_busy_q ? FillByte : req[b].wbyte;

    bml_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .row_i   (bank_row),
      .wbyte_i (bank_wbyte),
      .rbyte_o (rbyte[b])
    );
  end

  logic      s2_vld_q;
  acc_info_t s2_info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_info_q <= info;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: little-endian assembly, extension, result register
  // --------------------------------------------------------------------------
  logic [31:0]      asm_data;
  logic [31:0]      res_data;
  logic [LaneW-1:0] lane_sel [NumLanes];

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      lane_sel[k]          = s2_info_q.offset + LaneW'(k);
      asm_data[8*k +: 8]   = s2_info_q.byte_ok[k] ? rbyte[lane_sel[k]] : 8'h00;
    end
  end

  always_comb begin
    res_data = asm_data;
    if (s2_info_q.op == OpWrite) begin
      res_data = '0;
    end else if (s2_info_q.sign_extend) begin
      unique case (s2_info_q.access_size)
        SzByte:  res_data = {{24{asm_data[7]}}, asm_data[7:0]};
        SzHalf:  res_data = {{16{asm_data[15]}}, asm_data[15:0]};
        default: res_data = asm_data;
      endcase
    end
  end

  logic      done_q;
  out_item_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      res_q.rdata        <= res_data;
      res_q.out_of_range <= s2_info_q.oor;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== hdl/bml_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_port_props: port-level checks of the byte memory load/store block
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module bml_port_props
  import bml_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  in_i,
  input logic      done_o,
  input out_item_t result_o
);

  // every transfer gives exactly one result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("accepted command produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result without a matching command");

  // nothing is in flight while the fill pass runs
  a_quiet_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result during fill pass");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(in_i.op == OpWrite, 3)) |-> (result_o.rdata == 32'd0))
    else $error("store returned nonzero data");

  a_byte_zext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(in_i.op == OpRead && in_i.access_size == SzByte &&
                     !in_i.sign_extend, 3)) |-> (result_o.rdata[31:8] == 24'd0))
    else $error("unsigned byte load has upper bits set");

endmodule

bind byte_memory_load_store bml_port_props u_bml_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .in_i     (in_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== tb/sv/bml_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bml_checker: access predictor and result checker for the byte memory
// Keeps a shadow byte store and size limit, predicts each access on its
// command transfer and checks every result strobe against the oldest one.
// ----------------------------------------------------------------------------
module bml_checker
  import bml_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  in_item_t        cmd_i,
  input  logic            done_i,
  input  out_item_t       result_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  logic [7:0]      shadow_mem [MemBytes];
  logic [CfgW-1:0] size_in_use;
  out_item_t       expected_q [$];
  int unsigned     fails;

  // size in use rounded up to 16 bytes, saturated at the store size
  function automatic int unsigned byte_limit(input logic [CfgW-1:0] size);
    int unsigned lim;
    lim = (32'(size) + 32'd15) & 32'hFFFF_FFF0;
    if (lim > MemBytes) lim = MemBytes;
    return lim;
  endfunction

  // applies one access to the shadow store and returns its result
  function automatic out_item_t apply_access(input in_item_t cmd);
    out_item_t   res;
    int unsigned lanes;
    int unsigned lim;
    logic [31:0] a;
    logic [31:0] value;
    lanes = (cmd.access_size == SzByte) ? 1 : (cmd.access_size == SzHalf) ? 2 : 4;
    lim   = byte_limit(size_in_use);
    value = '0;
    res.out_of_range = 1'b0;
    for (int k = 0; k < lanes; k++) begin
      a = cmd.addr + 32'(k);
      if (a >= lim) begin
        res.out_of_range = 1'b1;
      end else if (cmd.op == OpWrite) begin
        shadow_mem[a[AddrW-1:0]] = cmd.wdata[8*k +: 8];
      end else begin
        value[8*k +: 8] = shadow_mem[a[AddrW-1:0]];
      end
    end
    if (cmd.op == OpRead && cmd.sign_extend) begin
      if (lanes == 1 && value[7]) value[31:8] = '1;
      else if (lanes == 2 && value[15]) value[31:16] = '1;
    end
    if (cmd.op == OpWrite) value = '0;
    res.rdata = value;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_mem[i]) shadow_mem[i] = FillByte;
      size_in_use = 13'd4096;
      expected_q.delete();
      fails = 0;
    end else begin
      out_item_t want;
      if (cfg_valid_i && cfg_ready_i) size_in_use = cfg_data_i;
      // results first: a command taken at this edge is always younger
      if (done_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with none pending", result_i.rdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (result_i.rdata !== want.rdata)
            report_mismatch("rdata", result_i.rdata, want.rdata);
          if (result_i.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", 32'(result_i.out_of_range),
                            32'(want.out_of_range));
        end
      end
      if (start_i && !busy_i) expected_q.push_back(apply_access(cmd_i));
    end
    fail_count_o = fails;
    pending_o    = expected_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top of the byte memory load/store test
// Drives directed and random accesses under several size settings and
// sender idle rates; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import bml_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumPhases   = 8;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            cmd_start = 1'b0;
  in_item_t        cmd       = '0;
  logic            cfg_valid = 1'b0;
  logic [CfgW-1:0] cfg_data  = '0;

  logic        cmd_busy;
  logic        done;
  out_item_t   result;
  logic        cfg_ready;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned idle_pct;   // chance in percent of a gap before each command
  int unsigned cur_size;   // last size written, only used to aim addresses

  // phase plan: size setting, sender idle rate, random command count
  int unsigned phase_size [NumPhases] = '{4096, 0, 20, 8191, 16, 4095, 1000, 0};
  int unsigned phase_idle [NumPhases] = '{0, 67, 31, 0, 67, 31, 0, 67};
  int unsigned phase_cnt  [NumPhases] = '{200, 60, 150, 200, 150, 150, 150, 150};

  always #1 clk_i = ~clk_i;

  byte_memory_load_store DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (cmd_start),
    .busy        (cmd_busy),
    .in_i        (cmd),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  bml_checker access_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cmd_start),
    .busy_i       (cmd_busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic in_item_t access(input logic op, input logic [1:0] sz,
                                      input logic sx, input logic [31:0] addr,
                                      input logic [31:0] wdata);
    in_item_t c;
    c.op          = op;
    c.access_size = sz;
    c.sign_extend = sx;
    c.addr        = addr;
    c.wdata       = wdata;
    return c;
  endfunction

  // random access; addresses mostly land in a small hot window so reads
  // see earlier writes, or around the limit and the 2^32 wrap
  function automatic in_item_t random_access(input int unsigned size);
    in_item_t    c;
    int unsigned span;
    int unsigned pick;
    span = (size + 15) & 32'hFFFF_FFF0;
    if (span > MemBytes) span = MemBytes;
    c.op          = 1'($urandom_range(0, 1));
    c.access_size = 2'($urandom_range(0, 3));
    c.sign_extend = 1'($urandom_range(0, 1));
    c.wdata       = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40)      c.addr = $urandom_range(0, 63);
    else if (pick < 70) c.addr = $urandom_range(0, span + 7);
    else if (pick < 80) c.addr = 32'hFFFF_FFF8 + $urandom_range(0, 7);
    else if (pick < 88) c.addr = span - 4 + $urandom_range(0, 7);
    else                c.addr = $urandom;
    return c;
  endfunction

  // one command transfer; start stays high if the next one follows at once
  task automatic issue(input in_item_t item);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_start <= 1'b0;
      cmd       <= random_access(cur_size);   // junk payload while idle
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    cmd_start <= 1'b1;
    cmd       <= item;
    do @(posedge clk_i); while (cmd_busy);
  endtask

  // stop issuing and let every outstanding result come back
  task automatic drain();
    cmd_start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // size register write, only while the block is idle
  task automatic write_size(input int unsigned size);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= CfgW'(size);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_size = size;
  endtask

  initial begin
    idle_pct = 0;
    cur_size = 4096;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fill pass after reset keeps busy high; issue() simply waits on it

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) phase_size[p] = $urandom_range(0, 8191);
      write_size(phase_size[p]);
      idle_pct = phase_idle[p];

      if (p == 0) begin
        // byte lanes, sign bits and the word overlay
        issue(access(OpWrite, SzWord, 1'b0, 32'h0000_0000, 32'h80FF_7F01));
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_0000, 32'h0));
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_0001, 32'h0));
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_0002, 32'h0));
        issue(access(OpRead,  SzByte, 1'b0, 32'h0000_0002, 32'h0));
        issue(access(OpRead,  SzHalf, 1'b1, 32'h0000_0002, 32'h0));
        issue(access(OpRead,  SzHalf, 1'b0, 32'h0000_0001, 32'h0));
        // word read ignores sign extension
        issue(access(OpRead,  SzWord, 1'b1, 32'h0000_0000, 32'h0));
        // fourth size code acts as a word, unaligned too
        issue(access(OpRead,  2'd3,   1'b1, 32'h0000_0001, 32'h0));
        issue(access(OpWrite, 2'd3,   1'b0, 32'h0000_0100, 32'hFFFF_FFFF));
        issue(access(OpRead,  SzWord, 1'b0, 32'h0000_0100, 32'h0));
        // straddling the top of the store: partial write, partial read
        issue(access(OpWrite, SzHalf, 1'b0, 32'h0000_0FFF, 32'h0000_1234));
        issue(access(OpRead,  SzWord, 1'b0, 32'h0000_0FFD, 32'h0));
        // address wrap at 2^32: top byte out, low bytes written
        issue(access(OpWrite, SzWord, 1'b1, 32'hFFFF_FFFF, 32'hDEAD_BEEF));
        issue(access(OpRead,  SzWord, 1'b1, 32'hFFFF_FFFE, 32'h0));
        issue(access(OpRead,  SzWord, 1'b0, 32'h0000_0000, 32'h0));
        // untouched bytes still hold the fill pattern
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_0800, 32'h0));
        issue(access(OpRead,  SzHalf, 1'b0, 32'h0000_0800, 32'h0));
        issue(access(OpWrite, SzByte, 1'b1, 32'h0000_0007, 32'hFFFF_FF80));
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_0007, 32'h0));
        // fully out of range
        issue(access(OpRead,  SzByte, 1'b1, 32'h0000_1000, 32'h0));
        issue(access(OpRead,  SzWord, 1'b0, 32'hFFFF_FFFC, 32'h0));
      end

      if (p == 2) begin
        // size 20 rounds up to 32: the word at 30 splits across the limit
        issue(access(OpWrite, SzWord, 1'b0, 32'h0000_001E, 32'h0403_0201));
        issue(access(OpRead,  SzWord, 1'b0, 32'h0000_001E, 32'h0));
      end

      repeat (phase_cnt[p]) issue(random_access(cur_size));
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("byte_memory_load_store test passed");
    end else begin
      $display("byte_memory_load_store test failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #200000;
    $display("byte_memory_load_store test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bml_pkg.sv
hdl/bml_bank.sv
hdl/bml_addr_gen.sv
hdl/byte_memory_load_store.sv
hdl/bml_checker.sv
tb/sv/bml_checker.sv
tb/sv/testbench.sv
